### rtl/core/raps_pkg.sv
// Package for the rolling average and peak statistics unit.
// Holds widths, register indexes, sequencer states and reset values.
// Depends on nothing; the interfaces, the divider and the top level use it.
`timescale 1ns / 1ps
package raps_pkg;
	localparam int unsigned MAX_WINDOW_DEF = 1024;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALM_POLICY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;
	localparam logic [10:0] WINDOW_LENGTH_RST = 11'd24;
	localparam logic [15:0] SCALE_FACTOR_RST = 16'd256;
	localparam logic [10:0] POLICY_LIMIT = 11'd24;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_SQUARE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_BEST,
		ST_FINAL_MEAN,
		ST_FINAL_MS,
		ST_FINAL_VAR,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctrl_t;
endpackage

### rtl/core/raps_if.sv
// Valid/ready channel interfaces for the statistics unit.
// Depends on raps_pkg for the configuration widths.
`timescale 1ns / 1ps
interface raps_in_if;
	logic valid;
	logic ready;
	logic [31:0] sample;
	logic calm_or_missing;
	logic last_of_series;
	modport source(output valid, sample, calm_or_missing, last_of_series, input ready);
	modport sink(input valid, sample, calm_or_missing, last_of_series, output ready);
endinterface

interface raps_out_if;
	logic valid;
	logic ready;
	logic [31:0] mean_value;
	logic [31:0] peak_value;
	logic [63:0] variance_value;
	logic [31:0] peak_window_average;
	logic window_average_valid;
	modport source(output valid, mean_value, peak_value, variance_value,
		peak_window_average, window_average_valid, input ready);
	modport sink(input valid, mean_value, peak_value, variance_value,
		peak_window_average, window_average_valid, output ready);
endinterface

interface raps_cfg_if;
	logic valid;
	logic ready;
	logic [raps_pkg::CFG_IDX_W-1:0] index;
	logic [raps_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/raps_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on raps_pkg for the control struct.
`timescale 1ns / 1ps
module raps_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [63:0]          dividend,
	input  logic [63:0]          divisor,
	output raps_pkg::div_ctrl_t  ctrl,
	output logic [63:0]          quotient
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	// Shift in the next dividend bit and try one subtraction.
	assign trial = {rem_q, quo_q[63]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign ctrl.start = start;
	assign ctrl.busy = busy_q;
	assign ctrl.done = done_q;
	assign quotient = quo_q;
endmodule

### rtl/core/rolling_average_peak_stats_unit.sv
// Rolling average and peak statistics over a series of scaled samples.
// Each accepted item passes MUL, SCALE, SQUARE and UPDATE, then DIVIDE and BEST when a
// window average is formed; a series end then adds the mean and mean-square divisions
// (FINAL_MEAN, FINAL_MS), FINAL_VAR and OUT, where its result item is made valid.
// Throughput: one item at a time; the output step waits while an earlier result is unread.
// Reset: arst_n clears all control state and totals; the sample ring needs none.
`timescale 1ns / 1ps
module rolling_average_peak_stats_unit #(
	parameter int unsigned MAX_WINDOW = raps_pkg::MAX_WINDOW_DEF
) (
	input  logic clk,
	input  logic arst_n,
	raps_in_if.sink   in_ch,
	raps_out_if.source out_ch,
	raps_cfg_if.sink  cfg
);
	localparam int unsigned AW = $clog2(MAX_WINDOW);
	localparam int unsigned LW = AW + 1;

	// Configuration registers. The window length is stored as written; its
	// effective value is clamped into 1..MAX_WINDOW below.
	logic [10:0] window_length_q;
	logic        calm_policy_q;
	logic [15:0] scale_factor_q;
	logic        clear_window_req;

	raps_pkg::seq_state_t state_q, state_d;

	// The ring memory holds the sample and its calm flag in one word.
	logic [32:0] ring_mem [MAX_WINDOW];
	logic [32:0] ring_rd_q;

	logic [AW-1:0] ptr_q;
	logic [LW-1:0] fill_q;
	logic [41:0]   wsum_q;
	logic [LW-1:0] wcalms_q;
	logic [31:0]   scount_q;
	logic [63:0]   ssum_q;
	logic [63:0]   ssq_q;
	logic [31:0]   speak_q;
	logic [31:0]   best_q;
	logic          best_valid_q;

	// Item holding registers.
	logic [31:0] sample_q;
	logic        calm_q;
	logic        last_q;
	logic [47:0] prod_q;
	logic [31:0] val_q;
	logic [63:0] sqr_q;
	logic [LW-1:0] len_q;
	logic [63:0] div_a_q, div_b_q;
	logic [31:0] mean_q;
	logic [63:0] ms_q;

	// Result register.
	logic        out_valid_q;
	logic [31:0] o_mean_q, o_peak_q, o_pwa_q;
	logic [63:0] o_var_q;
	logic        o_wav_q;
	logic        out_load;

	// Effective window length, clamped.
	logic [LW-1:0] eff_len;
	always_comb begin
		if (window_length_q == 11'd0)
			eff_len = LW'(1);
		else if ({21'd0, window_length_q} > 32'(MAX_WINDOW))
			eff_len = LW'(MAX_WINDOW);
		else
			eff_len = LW'(window_length_q);
	end

	assign cfg.ready = (state_q == raps_pkg::ST_IDLE);
	assign clear_window_req = cfg.valid && cfg.ready && (cfg.index == raps_pkg::REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= raps_pkg::WINDOW_LENGTH_RST;
			calm_policy_q <= 1'b1;
			scale_factor_q <= raps_pkg::SCALE_FACTOR_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				raps_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg.data[10:0];
				raps_pkg::REG_CALM_POLICY:   calm_policy_q <= cfg.data[0];
				raps_pkg::REG_SCALE_FACTOR:  scale_factor_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Shared divider.
	raps_pkg::div_ctrl_t div_ctrl;
	logic        div_start;
	logic [63:0] div_quo;

	raps_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a_q), .divisor(div_b_q), .ctrl(div_ctrl), .quotient(div_quo)
	);

	// The input only waits for the sequencer. A finished result sits in the result
	// register, and a later series end holds in the output step until it is taken.
	logic in_acc;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == raps_pkg::ST_IDLE);
	assign out_load = (state_q == raps_pkg::ST_OUT) && (!out_valid_q || out_ch.ready);

	// Window pointer after the wrap check, and the divisor for the average.
	logic [AW-1:0] idx;
	logic          evict;
	logic [41:0]   wsum_n;
	logic [LW-1:0] wcalms_n;
	logic [LW-1:0] fill_n;
	logic [LW-1:0] valid_n;
	logic [8:0]    fl_x;
	logic [20:0]   fl_prod;
	logic [4:0]    floor_n;
	logic [LW-1:0] divisor;

	always_comb begin
		idx = ({1'b0, ptr_q} >= len_q) ? '0 : ptr_q;
		evict = (fill_q >= len_q);
		wsum_n = wsum_q + 42'(val_q) - (evict ? 42'(ring_rd_q[31:0]) : 42'd0);
		wcalms_n = wcalms_q + LW'(calm_q) - (evict ? LW'(ring_rd_q[32]) : LW'(0));
		fill_n = evict ? len_q : fill_q + LW'(1);
		valid_n = (wcalms_n <= fill_n) ? fill_n - wcalms_n : '0;
		// floor((15n + 18) / 20) by multiplying with 3277 / 2^16, which is exact for
		// every n the policy rule covers.
		fl_x = ({4'd0, fill_n[4:0]} << 4) - {4'd0, fill_n[4:0]} + 9'd18;
		fl_prod = {12'd0, fl_x} * 21'd3277;
		floor_n = fl_prod[20:16];
		if (!calm_policy_q)
			divisor = fill_n;
		else if (fill_n <= LW'(raps_pkg::POLICY_LIMIT))
			divisor = (valid_n > LW'(floor_n)) ? valid_n : LW'(floor_n);
		else
			divisor = valid_n;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			raps_pkg::ST_IDLE:   if (in_acc) state_d = raps_pkg::ST_MUL;
			raps_pkg::ST_MUL:    state_d = raps_pkg::ST_SCALE;
			raps_pkg::ST_SCALE:  state_d = raps_pkg::ST_SQUARE;
			raps_pkg::ST_SQUARE: state_d = raps_pkg::ST_UPDATE;
			raps_pkg::ST_UPDATE: state_d = (divisor != '0) ? raps_pkg::ST_DIVIDE
				: (last_q ? raps_pkg::ST_FINAL_MEAN : raps_pkg::ST_IDLE);
			raps_pkg::ST_DIVIDE: if (div_ctrl.done) state_d = raps_pkg::ST_BEST;
			raps_pkg::ST_BEST:   state_d = last_q ? raps_pkg::ST_FINAL_MEAN : raps_pkg::ST_IDLE;
			raps_pkg::ST_FINAL_MEAN: if (div_ctrl.done) state_d = raps_pkg::ST_FINAL_MS;
			raps_pkg::ST_FINAL_MS:   if (div_ctrl.done) state_d = raps_pkg::ST_FINAL_VAR;
			raps_pkg::ST_FINAL_VAR:  state_d = raps_pkg::ST_OUT;
			raps_pkg::ST_OUT:        if (out_load) state_d = raps_pkg::ST_IDLE;
			default: state_d = raps_pkg::ST_IDLE;
		endcase
	end

	// Divider starts: window average in DIVIDE, mean on entering FINAL_MEAN,
	// mean square after the mean is ready.
	logic run_q;
	always_comb begin
		div_start = 1'b0;
		case (state_q)
			raps_pkg::ST_DIVIDE, raps_pkg::ST_FINAL_MEAN, raps_pkg::ST_FINAL_MS:
				div_start = !div_ctrl.busy && !div_ctrl.done && !run_q;
			default: div_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) run_q <= 1'b0;
		else if (state_d != state_q) run_q <= 1'b0;
		else if (div_start) run_q <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= raps_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Ring memory: read in SCALE (data in SQUARE), written in UPDATE.
	always_ff @(posedge clk) begin
		if (state_q == raps_pkg::ST_SCALE)
			ring_rd_q <= ring_mem[idx];
		if (state_q == raps_pkg::ST_UPDATE)
			ring_mem[idx] <= {calm_q, val_q};
	end

	// Series totals, updated in UPDATE with saturation.
	logic [31:0] scount_n;
	logic [63:0] ssum_q_n;
	logic [64:0] ssum_add, ssq_add;
	assign scount_n = (scount_q == 32'hFFFF_FFFF) ? scount_q : scount_q + 32'd1;
	assign ssum_add = {1'b0, ssum_q} + 65'(val_q);
	assign ssq_add = {1'b0, ssq_q} + {1'b0, sqr_q};
	assign ssum_q_n = ssum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ssum_add[63:0];

	// Datapath.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= in_ch.sample;
			calm_q <= in_ch.calm_or_missing;
			last_q <= in_ch.last_of_series;
			len_q <= eff_len;
		end
		if (state_q == raps_pkg::ST_MUL)
			prod_q <= (sample_q * scale_factor_q) >> 8;
		if (state_q == raps_pkg::ST_SCALE)
			val_q <= (prod_q[47:32] != '0) ? 32'hFFFF_FFFF : prod_q[31:0];
		if (state_q == raps_pkg::ST_SQUARE)
			sqr_q <= val_q * val_q;
		// With no window average the mean division is set up directly.
		if (state_q == raps_pkg::ST_UPDATE) begin
			if (divisor != '0) begin
				div_a_q <= 64'(wsum_n);
				div_b_q <= 64'(divisor);
			end else if (last_q) begin
				div_a_q <= ssum_q_n;
				div_b_q <= 64'(scount_n);
			end
		end
		if (state_q == raps_pkg::ST_BEST && last_q) begin
			div_a_q <= ssum_q;
			div_b_q <= 64'(scount_q);
		end
		if (state_q == raps_pkg::ST_FINAL_MEAN && div_ctrl.done) begin
			mean_q <= (div_quo[63:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
			div_a_q <= ssq_q;
		end
		if (state_q == raps_pkg::ST_FINAL_MS && div_ctrl.done)
			ms_q <= div_quo;
		if (state_q == raps_pkg::ST_FINAL_VAR)
			sqr_q <= mean_q * mean_q;
	end

	logic [31:0] avg;
	assign avg = (div_quo[63:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0; fill_q <= '0; wsum_q <= '0; wcalms_q <= '0;
			scount_q <= '0; ssum_q <= '0; ssq_q <= '0; speak_q <= '0;
			best_q <= '0; best_valid_q <= 1'b0;
		end else begin
			if (clear_window_req) begin
				ptr_q <= '0; fill_q <= '0; wsum_q <= '0; wcalms_q <= '0;
			end
			if (state_q == raps_pkg::ST_UPDATE) begin
				ptr_q <= ({1'b0, idx} + LW'(1) >= len_q) ? '0 : idx + AW'(1);
				fill_q <= fill_n;
				wsum_q <= wsum_n;
				wcalms_q <= wcalms_n;
				scount_q <= scount_n;
				ssum_q <= ssum_q_n;
				ssq_q <= ssq_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ssq_add[63:0];
				if (val_q > speak_q) speak_q <= val_q;
			end
			if (state_q == raps_pkg::ST_DIVIDE && div_ctrl.done) begin
				if (!best_valid_q || avg > best_q) best_q <= avg;
				best_valid_q <= 1'b1;
			end
			if (out_load) begin
				ptr_q <= '0; fill_q <= '0; wsum_q <= '0; wcalms_q <= '0;
				scount_q <= '0; ssum_q <= '0; ssq_q <= '0; speak_q <= '0;
				best_q <= '0; best_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_mean_q <= mean_q;
			o_peak_q <= speak_q;
			o_var_q <= (ms_q > sqr_q) ? ms_q - sqr_q : '0;
			o_pwa_q <= best_valid_q ? best_q : '0;
			o_wav_q <= best_valid_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.mean_value = o_mean_q;
	assign out_ch.peak_value = o_peak_q;
	assign out_ch.variance_value = o_var_q;
	assign out_ch.peak_window_average = o_pwa_q;
	assign out_ch.window_average_valid = o_wav_q;
endmodule

### rtl/core/raps_checker.sv
// Port-level checker for the statistics unit, bound to the top level.
// Depends on the channel interfaces only through the top level's ports.
`timescale 1ns / 1ps
module raps_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] pwa,
	input logic wav,
	input logic cfg_valid,
	input logic cfg_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last |=> !in_ready) else $error("second item taken");
	a_pwa_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wav |-> pwa == 32'd0) else $error("average without valid");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !cfg_ready) else $error("config open while busy");
	a_cfg_keeps_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && !in_valid |=> in_ready) else $error("write left unit busy");
endmodule

bind rolling_average_peak_stats_unit raps_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_of_series),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.pwa(out_ch.peak_window_average), .wav(out_ch.window_average_valid),
	.cfg_valid(cfg.valid), .cfg_ready(cfg.ready)
);
